[hdl/ryv_pkg.sv]
// shared constants, types and the arctangent table for the y-axis rotator
`timescale 1ns / 1ps

package ryv_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int ANGLE_WIDTH    = 16;
    localparam int ANGLE_SHIFT    = 17;
    localparam int Q30_SHIFT      = 30;
    localparam int CORDIC_STAGES  = 31;
    localparam int QW             = 34;
    localparam int ROT_STAGES     = 3;
    localparam int PIPE_STAGES    = CORDIC_STAGES + ROT_STAGES + 1;

    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [QW-1:0]          t_qword;

    localparam t_angle ANGLE_MAX = 16'sd25736;
    localparam t_angle ANGLE_MIN = -16'sd25736;
    // first angle codes whose q30 value lies beyond a quarter turn
    localparam t_angle FOLD_POS  = 16'sd12868;
    localparam t_angle FOLD_NEG  = -16'sd12868;

    localparam t_qword PI_Q30    = 34'sd3373259426;
    localparam t_qword GAIN_INV  = 34'sh026DD3B6A;

    localparam t_qword ATAN_Q30 [CORDIC_STAGES] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F,
        34'sh00000003F, 34'sh00000001F, 34'sh00000000F, 34'sh000000008,
        34'sh000000004, 34'sh000000002, 34'sh000000001
    };

endpackage

[hdl/ryv_in_if.sv]
// input channel: vector and angle with valid/ready
`timescale 1ns / 1ps

interface ryv_in_if #(
    parameter int CW = ryv_pkg::COMP_WIDTH_DEF
);
    logic                                    valid;
    logic                                    ready;
    logic signed [CW-1:0]                    vec_x;
    logic signed [CW-1:0]                    vec_y;
    logic signed [CW-1:0]                    vec_z;
    logic signed [ryv_pkg::ANGLE_WIDTH-1:0]  angle_rad;

    modport source (output valid, vec_x, vec_y, vec_z, angle_rad, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, angle_rad, output ready);
endinterface

[hdl/ryv_out_if.sv]
// output channel: rotated vector with valid/ready
`timescale 1ns / 1ps

interface ryv_out_if #(
    parameter int CW = ryv_pkg::COMP_WIDTH_DEF,
    parameter int FB = ryv_pkg::FRAC_BITS_DEF
);
    localparam int OW = CW + FB + 1;

    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] rot_x;
    logic signed [CW-1:0] rot_y;
    logic signed [OW-1:0] rot_z;

    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

[hdl/ryv_prep.sv]
// entry stage: angle clamp, quarter-turn fold and cordic start values
`timescale 1ns / 1ps

module ryv_prep #(
    parameter int CW = ryv_pkg::COMP_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [CW-1:0]         i_vec_x,
    input  logic signed [CW-1:0]         i_vec_y,
    input  logic signed [CW-1:0]         i_vec_z,
    input  ryv_pkg::t_angle              i_angle,
    output logic                         o_valid,
    output ryv_pkg::t_qword              o_x,
    output ryv_pkg::t_qword              o_y,
    output ryv_pkg::t_qword              o_z,
    output logic signed [CW:0]           o_vx,
    output logic signed [CW-1:0]         o_vy,
    output logic signed [CW:0]           o_vz
);
    import ryv_pkg::*;

    logic              r_valid;
    t_qword            r_z;
    logic signed [CW:0] r_vx;
    logic signed [CW:0] r_vz;
    logic signed [CW-1:0] r_vy;

    t_angle            w_ang;
    t_qword            w_ang_q;
    t_qword            n_z;
    logic              w_flip;
    logic signed [CW:0] w_vx;
    logic signed [CW:0] w_vz;

    always_comb begin
        priority if (i_angle > ANGLE_MAX) begin
            w_ang = ANGLE_MAX;
        end else if (i_angle < ANGLE_MIN) begin
            w_ang = ANGLE_MIN;
        end else begin
            w_ang = i_angle;
        end
        w_ang_q = {{(QW-ANGLE_WIDTH-ANGLE_SHIFT){w_ang[ANGLE_WIDTH-1]}}, w_ang,
                   {ANGLE_SHIFT{1'b0}}};
        priority if (w_ang >= FOLD_POS) begin
            n_z    = w_ang_q - PI_Q30;
            w_flip = 1'b1;
        end else if (w_ang <= FOLD_NEG) begin
            n_z    = w_ang_q + PI_Q30;
            w_flip = 1'b1;
        end else begin
            n_z    = w_ang_q;
            w_flip = 1'b0;
        end
        // negating the vector stands in for negating cos and sin
        w_vx = {i_vec_x[CW-1], i_vec_x};
        w_vz = {i_vec_z[CW-1], i_vec_z};
        if (w_flip) begin
            w_vx = -w_vx;
            w_vz = -w_vz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z  <= n_z;
            r_vx <= w_vx;
            r_vz <= w_vz;
            r_vy <= i_vec_y;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = GAIN_INV;
    assign o_y     = '0;
    assign o_z     = r_z;
    assign o_vx    = r_vx;
    assign o_vy    = r_vy;
    assign o_vz    = r_vz;

endmodule

[hdl/ryv_cordic_stage.sv]
// one rotation-mode cordic iteration with its register
`timescale 1ns / 1ps

module ryv_cordic_stage #(
    parameter int CW  = ryv_pkg::COMP_WIDTH_DEF,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ryv_pkg::t_qword      i_x,
    input  ryv_pkg::t_qword      i_y,
    input  ryv_pkg::t_qword      i_z,
    input  logic signed [CW:0]   i_vx,
    input  logic signed [CW-1:0] i_vy,
    input  logic signed [CW:0]   i_vz,
    output logic                 o_valid,
    output ryv_pkg::t_qword      o_x,
    output ryv_pkg::t_qword      o_y,
    output ryv_pkg::t_qword      o_z,
    output logic signed [CW:0]   o_vx,
    output logic signed [CW-1:0] o_vy,
    output logic signed [CW:0]   o_vz
);
    import ryv_pkg::*;

    logic                 r_valid;
    t_qword               r_x;
    t_qword               r_y;
    t_qword               r_z;
    logic signed [CW:0]   r_vx;
    logic signed [CW-1:0] r_vy;
    logic signed [CW:0]   r_vz;

    t_qword w_dx;
    t_qword w_dy;
    t_qword n_x;
    t_qword n_y;
    t_qword n_z;

    always_comb begin
        w_dx = i_y >>> IDX;
        w_dy = i_x >>> IDX;
        if (!i_z[QW-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN_Q30[IDX];
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN_Q30[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_vx <= i_vx;
            r_vy <= i_vy;
            r_vz <= i_vz;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_vx    = r_vx;
    assign o_vy    = r_vy;
    assign o_vz    = r_vz;

endmodule

[hdl/ryv_rotate.sv]
// products, sums and round/saturate stages feeding the output register
`timescale 1ns / 1ps

module ryv_rotate #(
    parameter int CW = ryv_pkg::COMP_WIDTH_DEF,
    parameter int FB = ryv_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [ryv_pkg::ROT_STAGES-1:0]        i_en,
    input  logic                                  i_valid,
    input  ryv_pkg::t_qword                       i_c,
    input  ryv_pkg::t_qword                       i_s,
    input  logic signed [CW:0]                    i_vx,
    input  logic signed [CW-1:0]                  i_vy,
    input  logic signed [CW:0]                    i_vz,
    output logic [ryv_pkg::ROT_STAGES-1:0]        o_valid,
    output logic signed [CW+FB:0]                 o_rot_x,
    output logic signed [CW-1:0]                  o_rot_y,
    output logic signed [CW+FB:0]                 o_rot_z
);
    import ryv_pkg::*;

    localparam int OW = CW + FB + 1;
    localparam int PW = CW + 1 + QW;
    localparam int SW = PW + 1;
    localparam int SH = Q30_SHIFT - FB;
    localparam logic signed [SW-1:0] HALF    = {{(SW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
    localparam logic signed [SW-1:0] OUT_MAX = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [SW-1:0] OUT_MIN = -OUT_MAX;

    logic [ROT_STAGES-1:0] r_valid;
    logic signed [PW-1:0]  r_xc;
    logic signed [PW-1:0]  r_zs;
    logic signed [PW-1:0]  r_xs;
    logic signed [PW-1:0]  r_zc;
    logic signed [SW-1:0]  r_sx;
    logic signed [SW-1:0]  r_sz;
    logic signed [OW-1:0]  r_rot_x;
    logic signed [OW-1:0]  r_rot_z;
    logic signed [CW-1:0]  r_vy_a;
    logic signed [CW-1:0]  r_vy_b;
    logic signed [CW-1:0]  r_vy_c;

    logic signed [SW-1:0]  w_rx;
    logic signed [SW-1:0]  w_rz;
    logic signed [SW-1:0]  n_rot_x;
    logic signed [SW-1:0]  n_rot_z;

    always_comb begin
        w_rx = (r_sx + HALF) >>> SH;
        w_rz = (r_sz + HALF) >>> SH;
        priority if (w_rx > OUT_MAX) begin
            n_rot_x = OUT_MAX;
        end else if (w_rx < OUT_MIN) begin
            n_rot_x = OUT_MIN;
        end else begin
            n_rot_x = w_rx;
        end
        priority if (w_rz > OUT_MAX) begin
            n_rot_z = OUT_MAX;
        end else if (w_rz < OUT_MIN) begin
            n_rot_z = OUT_MIN;
        end else begin
            n_rot_z = w_rz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_en[0]) begin
                r_valid[0] <= i_valid;
            end
            if (i_en[1]) begin
                r_valid[1] <= r_valid[0];
            end
            if (i_en[2]) begin
                r_valid[2] <= r_valid[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xc   <= PW'(i_vx) * PW'(i_c);
            r_zs   <= PW'(i_vz) * PW'(i_s);
            r_xs   <= PW'(i_vx) * PW'(i_s);
            r_zc   <= PW'(i_vz) * PW'(i_c);
            r_vy_a <= i_vy;
        end
        if (i_en[1]) begin
            r_sx   <= SW'(r_xc) - SW'(r_zs);
            r_sz   <= SW'(r_xs) + SW'(r_zc);
            r_vy_b <= r_vy_a;
        end
        if (i_en[2]) begin
            r_rot_x <= n_rot_x[OW-1:0];
            r_rot_z <= n_rot_z[OW-1:0];
            r_vy_c  <= r_vy_b;
        end
    end

    assign o_valid = r_valid;
    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_vy_c;
    assign o_rot_z = r_rot_z;

endmodule

[hdl/rotate_vector_about_y_top.sv]
// rotation of an integer 3d vector about the y axis, top level
//
// i_in carries vec_x, vec_y, vec_z and angle_rad (signed q3.13 radians,
// clamped to +-pi). o_out carries rot_x = x*cos - z*sin and
// rot_z = x*sin + z*cos with FRACTION_BITS fraction bits, rounded half up
// and saturated, and rot_y = vec_y unchanged. one result item per item.
// an item is taken when valid and ready are both high.
// from acceptance to valid result: registered angle clamp and fold,
// 31 cordic iterations of one register each, then
// multiply, sum, and round/saturate into the output register.
// throughput: one item per cycle, fully pipelined, while not stalled.
// each stage holds only while it is full and the stage after it is held,
// so empty stages keep filling and i_in.ready stays high while a result
// waits, until every stage holds an item.
// reset clears all valid bits; no result is presented after reset until
// an item has passed the pipeline. nothing is lost or repeated on stalls.
`timescale 1ns / 1ps

module rotate_vector_about_y_top #(
    parameter int COMPONENT_WIDTH = ryv_pkg::COMP_WIDTH_DEF,
    parameter int FRACTION_BITS   = ryv_pkg::FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ryv_in_if.sink   i_in,
    ryv_out_if.source o_out
);
    import ryv_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int OW = COMPONENT_WIDTH + FRACTION_BITS + 1;
    localparam int LS = PIPE_STAGES - 1;

    logic [PIPE_STAGES-1:0] w_en;
    logic [PIPE_STAGES-1:0] w_valid;

    t_qword               w_x  [CORDIC_STAGES+1];
    t_qword               w_y  [CORDIC_STAGES+1];
    t_qword               w_z  [CORDIC_STAGES+1];
    logic signed [CW:0]   w_vx [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_vy [CORDIC_STAGES+1];
    logic signed [CW:0]   w_vz [CORDIC_STAGES+1];

    // a stage loads when it is empty or the next stage loads
    always_comb begin
        w_en[LS] = !w_valid[LS] || o_out.ready;
        for (int k = LS - 1; k >= 0; k--) begin
            w_en[k] = !w_valid[k] || w_en[k+1];
        end
    end

    ryv_prep #(
        .CW (CW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[0]),
        .i_valid (i_in.valid),
        .i_vec_x (i_in.vec_x),
        .i_vec_y (i_in.vec_y),
        .i_vec_z (i_in.vec_z),
        .i_angle (i_in.angle_rad),
        .o_valid (w_valid[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0]),
        .o_vx    (w_vx[0]),
        .o_vy    (w_vy[0]),
        .o_vz    (w_vz[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        ryv_cordic_stage #(
            .CW  (CW),
            .IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g+1]),
            .i_valid (w_valid[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_vx    (w_vx[g]),
            .i_vy    (w_vy[g]),
            .i_vz    (w_vz[g]),
            .o_valid (w_valid[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_vx    (w_vx[g+1]),
            .o_vy    (w_vy[g+1]),
            .o_vz    (w_vz[g+1])
        );
    end

    ryv_rotate #(
        .CW (CW),
        .FB (FRACTION_BITS)
    ) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[LS -: ROT_STAGES]),
        .i_valid (w_valid[CORDIC_STAGES]),
        .i_c     (w_x[CORDIC_STAGES]),
        .i_s     (w_y[CORDIC_STAGES]),
        .i_vx    (w_vx[CORDIC_STAGES]),
        .i_vy    (w_vy[CORDIC_STAGES]),
        .i_vz    (w_vz[CORDIC_STAGES]),
        .o_valid (w_valid[LS -: ROT_STAGES]),
        .o_rot_x (o_out.rot_x),
        .o_rot_y (o_out.rot_y),
        .o_rot_z (o_out.rot_z)
    );

    assign i_in.ready  = w_en[0];
    assign o_out.valid = w_valid[LS];

    a_full_stall_blocks_input : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (&w_valid && !o_out.ready) |-> !i_in.ready
    ) else $error("input taken while pipeline full and stalled");

    a_accept_fills_entry : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> w_valid[0]
    ) else $error("accepted item missing from entry stage");

    a_sat_symmetric : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.rot_x != {1'b1, {(OW-1){1'b0}}}) &&
                        (o_out.rot_z != {1'b1, {(OW-1){1'b0}}})
    ) else $error("result outside symmetric saturation range");

    a_empty_output_ready : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[LS] |-> w_en[LS]
    ) else $error("empty output register not loading");

endmodule
